// ----- hw/rtl/multi_queue_mailbox_core_macros.svh -----
`ifndef MULTI_QUEUE_MAILBOX_CORE_MACROS_SVH
`define MULTI_QUEUE_MAILBOX_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define MQM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mailbox check failed");

// next-cycle implication, sampled on clock, off during reset
`define MQM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mailbox check failed");

`endif

// ----- hw/rtl/mqm_pkg.sv -----
package mqm_pkg;

   localparam int NUM_BOXES_DEF   = 32;
   localparam int QUEUE_DEPTH_DEF = 128;
   localparam int MSG_WIDTH_DEF   = 32;
   localparam int FIXED_BOXES     = 10;
   localparam int BROADCAST_BOX   = 9;

   localparam int ACTION_W = 3;
   localparam int BOX_IN_W = 5;
   localparam int SENDER_W = 8;
   localparam int MSG_IN_W = 32;
   localparam int PEND_W   = 8;
   localparam int DELIV_W  = 5;

   localparam logic [ACTION_W-1:0] ACT_POST     = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_FETCH    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_BCAST    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_SET_PERM = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_STATUS   = 3'd5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_LOCAL_SENDER = 1'b0;
   localparam logic [SENDER_W-1:0] LOCAL_SENDER_RST = 8'd1;

   localparam logic [DELIV_W-1:0] DELIV_MAX = '1;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [BOX_IN_W-1:0] box;
      logic [SENDER_W-1:0] sender_id;
      logic [MSG_IN_W-1:0] message;
      logic                allow_flag;
   } mqm_req_type;

   typedef struct packed {
      logic                ok;
      logic [SENDER_W-1:0] sender_out;
      logic [MSG_IN_W-1:0] message_out;
      logic [PEND_W-1:0]   pending;
      logic                allowed_out;
      logic [DELIV_W-1:0]  delivered;
   } mqm_rsp_type;

endpackage

// ----- hw/rtl/multi_queue_mailbox_core.sv -----
// sequence: box state read, execute and write-back, then response; a fetch that finds an
// entry adds a queue read; a new request is taken only back in idle, after the response
// is issued; a broadcast does a box state memory read/modify/write per mailbox
// reset: synchronous, clears sequencer, response valid and per-box valid bits;
// no clearing pass, mailboxes read as their reset state until first written
`include "multi_queue_mailbox_core_macros.svh"

module multi_queue_mailbox_core #(
   parameter int NUM_BOXES   = mqm_pkg::NUM_BOXES_DEF,
   parameter int QUEUE_DEPTH = mqm_pkg::QUEUE_DEPTH_DEF,
   parameter int MSG_WIDTH   = mqm_pkg::MSG_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  mqm_pkg::mqm_req_type           req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output mqm_pkg::mqm_rsp_type           rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [mqm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mqm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mqm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import mqm_pkg::*;

   logic [SENDER_W-1:0] local_sender;
   logic                sender_wr;
   logic                sender_rd;

   mqm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .local_sender (local_sender)
   );

   mqm_seq #(
      .NUM_BOXES   (NUM_BOXES),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MSG_WIDTH   (MSG_WIDTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .local_sender (local_sender)
   );

   assign sender_rd = csr_psel && (csr_paddr[CSR_ADDR_W-1] == REG_LOCAL_SENDER);
   assign sender_wr = sender_rd && csr_penable && csr_pwrite;

   `MQM_ASSERT_NEXT(a_busy_after_request, req_valid && !req_stall, req_stall)
   `MQM_ASSERT_NEXT(a_sender_readback, sender_wr, !sender_rd || (csr_prdata[SENDER_W-1:0] == $past(csr_pwdata[SENDER_W-1:0])))

endmodule

// ----- hw/rtl/mqm_ram.sv -----
module mqm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/mqm_csr.sv -----
module mqm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mqm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [mqm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [mqm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output logic [mqm_pkg::SENDER_W-1:0]    local_sender
);
   import mqm_pkg::*;

   logic [SENDER_W-1:0] local_sender_ff;
   logic [SENDER_W-1:0] local_sender_in;
   logic                reg_sel;

   assign reg_sel = (csr_paddr[CSR_ADDR_W-1] == REG_LOCAL_SENDER);

   always_comb begin
      local_sender_in = local_sender_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_sel) begin
         local_sender_in = csr_pwdata[SENDER_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_sender_ff <= LOCAL_SENDER_RST;
      end else begin
         local_sender_ff <= local_sender_in;
      end
   end

   assign csr_prdata   = (csr_psel && reg_sel) ? CSR_DATA_W'(local_sender_ff) : '0;
   assign csr_pready   = 1'b1;
   assign local_sender = local_sender_ff;

endmodule

// ----- hw/rtl/mqm_seq.sv -----
module mqm_seq #(
   parameter int NUM_BOXES   = mqm_pkg::NUM_BOXES_DEF,
   parameter int QUEUE_DEPTH = mqm_pkg::QUEUE_DEPTH_DEF,
   parameter int MSG_WIDTH   = mqm_pkg::MSG_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  mqm_pkg::mqm_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output mqm_pkg::mqm_rsp_type          rsp_data,
   input  logic [mqm_pkg::SENDER_W-1:0]  local_sender
);
   import mqm_pkg::*;

   localparam int BOX_W   = $clog2(NUM_BOXES);
   localparam int CNT_W   = $clog2(NUM_BOXES + 1);
   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = SENDER_W + MSG_WIDTH;
   localparam int Q_DEPTH = NUM_BOXES * (2 ** PTR_W);

   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);
   localparam logic [BOX_W-1:0]  BOX_ONE   = BOX_W'(1);
   localparam logic [BOX_W-1:0]  BOX_FIXED = BOX_W'(FIXED_BOXES);
   localparam logic [CNT_W-1:0]  IDX_FIRST = CNT_W'(1);
   localparam logic [CNT_W-1:0]  IDX_BCAST = CNT_W'(BROADCAST_BOX);
   localparam logic [CNT_W-1:0]  IDX_END   = CNT_W'(NUM_BOXES);

   typedef struct packed {
      logic              active;
      logic              allowed;
      logic [PTR_W-1:0]  wptr;
      logic [PTR_W-1:0]  rptr;
      logic [FILL_W-1:0] fill;
   } box_state_type;

   localparam int ST_W = $bits(box_state_type);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_RD     = 9'b000000010,
      S_EX     = 9'b000000100,
      S_FETCH  = 9'b000001000,
      S_BC_RD  = 9'b000010000,
      S_BC_EX  = 9'b000100000,
      S_FIN_RD = 9'b001000000,
      S_FIN    = 9'b010000000,
      S_OUT    = 9'b100000000
   } seq_state_type;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   seq_state_type       state_ff, state_in;
   logic [ACTION_W-1:0] act_ff, act_in;
   logic [BOX_W-1:0]    box_ff, box_in;
   logic [SENDER_W-1:0] snd_ff, snd_in;
   logic [MSG_WIDTH-1:0] msg_ff, msg_in;
   logic                allow_ff, allow_in;
   logic [CNT_W-1:0]    bc_idx_ff, bc_idx_in;
   logic                bc_last_ff, bc_last_in;
   logic [DELIV_W-1:0]  deliv_ff, deliv_in;
   logic                ok_ff, ok_in;
   logic [SENDER_W-1:0] sender_out_ff, sender_out_in;
   logic [MSG_IN_W-1:0] message_out_ff, message_out_in;
   logic [PEND_W-1:0]   pending_ff, pending_in;
   logic                allowed_out_ff, allowed_out_in;
   logic                rsp_valid_ff, rsp_valid_in;
   mqm_rsp_type         rsp_data_ff, rsp_data_in;
   logic [NUM_BOXES-1:0] valid_ff, valid_in;
   logic [BOX_W-1:0]    rd_box_ff, rd_box_in;
   logic                rd_valid_ff, rd_valid_in;

   logic                st_rd_en;
   logic [BOX_W-1:0]    st_rd_addr;
   logic [ST_W-1:0]     st_rd_data;
   logic                st_wr_en;
   box_state_type       st_new;

   logic                q_wr_en;
   logic                q_rd_en;
   logic [BOX_W+PTR_W-1:0] q_rd_addr;
   logic [ENTRY_W-1:0]  q_rd_data;

   box_state_type       cur_state;
   box_state_type       rst_state;
   box_state_type       ex_state;
   box_state_type       post_out;
   logic                can_post;
   logic [CNT_W-1:0]    idx_next;
   logic [BOX_W-1:0]    req_box;

   // box state as last written, or its value after reset
   always_comb begin
      rst_state         = '0;
      rst_state.active  = (rd_box_ff < BOX_FIXED);
      rst_state.allowed = 1'b1;
      cur_state = rd_valid_ff ? box_state_type'(st_rd_data) : rst_state;
      ex_state  = cur_state;
      if (!cur_state.active) begin
         ex_state         = '0;
         ex_state.active  = 1'b1;
         ex_state.allowed = 1'b1;
      end
   end

   // shared post unit, drops the oldest entry when full
   always_comb begin
      post_out = ex_state;
      if (ex_state.fill == FILL_FULL) begin
         post_out.rptr = ptr_inc(ex_state.rptr);
      end else begin
         post_out.fill = ex_state.fill + 1'b1;
      end
      post_out.wptr = ptr_inc(ex_state.wptr);
   end

   assign can_post = (bc_last_ff || cur_state.active) && cur_state.allowed;
   assign req_box  = (32'(req_data.box) >= NUM_BOXES) ? BOX_ONE : BOX_W'(req_data.box);

   always_comb begin
      idx_next = bc_idx_ff + 1'b1;
      if (idx_next == IDX_BCAST) begin
         idx_next = bc_idx_ff + CNT_W'(2);
      end
   end

   always_comb begin
      state_in       = state_ff;
      act_in         = act_ff;
      box_in         = box_ff;
      snd_in         = snd_ff;
      msg_in         = msg_ff;
      allow_in       = allow_ff;
      bc_idx_in      = bc_idx_ff;
      bc_last_in     = bc_last_ff;
      deliv_in       = deliv_ff;
      ok_in          = ok_ff;
      sender_out_in  = sender_out_ff;
      message_out_in = message_out_ff;
      pending_in     = pending_ff;
      allowed_out_in = allowed_out_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      valid_in       = valid_ff;
      st_rd_en       = 1'b0;
      st_rd_addr     = box_ff;
      st_wr_en       = 1'b0;
      st_new         = ex_state;
      q_wr_en        = 1'b0;
      q_rd_en        = 1'b0;
      q_rd_addr      = {box_ff, ex_state.rptr};

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in         = req_data.action;
               box_in         = req_box;
               snd_in         = (req_data.sender_id == '0) ? local_sender : req_data.sender_id;
               msg_in         = MSG_WIDTH'(req_data.message);
               allow_in       = req_data.allow_flag;
               deliv_in       = '0;
               ok_in          = 1'b0;
               sender_out_in  = '0;
               message_out_in = '0;
               bc_last_in     = 1'b0;
               state_in       = S_RD;
            end
         end
         S_RD: begin
            st_rd_en = 1'b1;
            state_in = S_EX;
         end
         S_EX: begin
            st_wr_en = 1'b1;
            state_in = S_OUT;
            case (act_ff)
               ACT_POST: begin
                  if (ex_state.allowed) begin
                     st_new  = post_out;
                     q_wr_en = 1'b1;
                     ok_in   = 1'b1;
                  end
               end
               ACT_FETCH: begin
                  if (ex_state.fill != '0) begin
                     st_new.rptr = ptr_inc(ex_state.rptr);
                     st_new.fill = ex_state.fill - 1'b1;
                     q_rd_en     = 1'b1;
                     ok_in       = 1'b1;
                     state_in    = S_FETCH;
                  end
               end
               ACT_BCAST: begin
                  bc_idx_in = IDX_FIRST;
                  state_in  = S_BC_RD;
               end
               ACT_CLEAR: begin
                  st_new.wptr = '0;
                  st_new.rptr = '0;
                  st_new.fill = '0;
               end
               ACT_SET_PERM: begin
                  st_new.allowed = allow_ff;
               end
               ACT_STATUS: begin
                  st_new = ex_state;
               end
               default: begin
                  st_new = ex_state;
               end
            endcase
            pending_in     = PEND_W'(st_new.fill);
            allowed_out_in = st_new.allowed;
            valid_in[rd_box_ff] = 1'b1;
         end
         S_FETCH: begin
            sender_out_in  = q_rd_data[ENTRY_W-1 -: SENDER_W];
            message_out_in = MSG_IN_W'(q_rd_data[MSG_WIDTH-1:0]);
            state_in       = S_OUT;
         end
         S_BC_RD: begin
            st_rd_en   = 1'b1;
            st_rd_addr = bc_idx_ff[BOX_W-1:0];
            state_in   = S_BC_EX;
         end
         S_BC_EX: begin
            if (can_post) begin
               st_new   = post_out;
               st_wr_en = 1'b1;
               q_wr_en  = 1'b1;
               valid_in[rd_box_ff] = 1'b1;
            end
            if (bc_last_ff) begin
               ok_in    = can_post;
               state_in = S_FIN_RD;
            end else begin
               if (can_post && deliv_ff != DELIV_MAX) begin
                  deliv_in = deliv_ff + 1'b1;
               end
               if (idx_next == IDX_END) begin
                  bc_idx_in  = IDX_BCAST;
                  bc_last_in = 1'b1;
               end else begin
                  bc_idx_in = idx_next;
               end
               state_in = S_BC_RD;
            end
         end
         S_FIN_RD: begin
            st_rd_en = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            pending_in     = PEND_W'(cur_state.fill);
            allowed_out_in = cur_state.allowed;
            state_in       = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.ok          = ok_ff;
               rsp_data_in.sender_out  = sender_out_ff;
               rsp_data_in.message_out = message_out_ff;
               rsp_data_in.pending     = pending_ff;
               rsp_data_in.allowed_out = allowed_out_ff;
               rsp_data_in.delivered   = deliv_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rd_box_in   = st_rd_en ? st_rd_addr : rd_box_ff;
   assign rd_valid_in = st_rd_en ? valid_ff[st_rd_addr] : rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      box_ff         <= box_in;
      snd_ff         <= snd_in;
      msg_ff         <= msg_in;
      allow_ff       <= allow_in;
      bc_idx_ff      <= bc_idx_in;
      bc_last_ff     <= bc_last_in;
      deliv_ff       <= deliv_in;
      ok_ff          <= ok_in;
      sender_out_ff  <= sender_out_in;
      message_out_ff <= message_out_in;
      pending_ff     <= pending_in;
      allowed_out_ff <= allowed_out_in;
      rsp_data_ff    <= rsp_data_in;
      rd_box_ff      <= rd_box_in;
      rd_valid_ff    <= rd_valid_in;
   end

   mqm_ram #(
      .WIDTH (ST_W),
      .DEPTH (NUM_BOXES)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (rd_box_ff),
      .wr_data (st_new),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   mqm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (Q_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr ({rd_box_ff, ex_state.wptr}),
      .wr_data ({snd_ff, msg_ff}),
      .rd_en   (q_rd_en),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
